// ===== rtl/core/id3fs_pkg.sv =====
// -----------------------------------------------------------------------------
// ID3v2 frame scanner package
// Shared types, character bounds and helper functions for the frame scanner.
// -----------------------------------------------------------------------------
package id3fs_pkg;

   // Scanner phase.
   typedef enum logic [1:0] {
      PH_SCAN    = 2'd0,
      PH_FLAGS   = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   localparam int unsigned WIN_DEPTH   = 8;
   localparam int unsigned ID_BYTES    = 4;
   localparam int unsigned SIZE_W      = 28;
   localparam int unsigned ID_W        = 32;
   localparam int unsigned FILL_W      = 4;
   localparam int unsigned FLAG_W      = 2;
   localparam int unsigned TDATA_OUT_W = 72;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

   localparam logic [FILL_W-1:0] FILL_FULL   = FILL_W'(WIN_DEPTH);
   localparam logic [FLAG_W-1:0] FLAG_BYTES  = 2'd2;

   typedef logic [7:0] byte_type;
   typedef byte_type   window_type [WIN_DEPTH];

   // An identifier character is an uppercase letter or a decimal digit.
   function automatic logic is_id_char(input byte_type c);
      return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
             ((c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9));
   endfunction

   // Syncsafe size: seven bits from each of the last four window bytes.
   function automatic logic [SIZE_W-1:0] syncsafe_size(input window_type w);
      return {w[4][6:0], w[5][6:0], w[6][6:0], w[7][6:0]};
   endfunction

   function automatic logic [ID_W-1:0] window_id(input window_type w);
      return {w[0], w[1], w[2], w[3]};
   endfunction

endpackage

// ===== rtl/core/id3v2_frame_scanner_top.sv =====
// -----------------------------------------------------------------------------
// ID3v2 frame scanner
// Finds ID3v2 frame headers in a byte stream and forwards their payload bytes.
// -----------------------------------------------------------------------------
//
// Channel  Direction  tdata                               tuser / tlast
// req_     in         [7:0] data byte                     tlast: end of tag
// rsp_     out        [31:0] frame id, [59:32] frame      tuser[0]: kind,
//                     size, [67:60] payload byte          tuser[1]: truncated;
//                                                         tlast: last of frame
//
// One input beat is taken per clock cycle while the result register is free or
// being drained. The result of a beat, if it has one, appears in the result
// register in the cycle after acceptance; the window compare and the payload
// counter sit between the state registers and that result register.
// Reset is synchronous and active high; it empties the window and returns the
// scanner to its search phase. A stalled result register holds off input
// beats only while it is full and not being taken.
//
// The eight-byte window shifts only while searching. Once a header is found it
// keeps the header bytes, so frame id and size are reported on every payload
// beat of that frame. Two flag bytes are skipped after a header, then the
// payload bytes are forwarded with the final one marked. The end of the tag
// always returns the scanner to searching with an empty window.
module id3v2_frame_scanner_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_tag

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] frame_id, [59:32] frame_len,
                                    // [67:60] payload_byte, [71:68] zero
   output logic [1:0]  rsp_tuser,   // [0] kind, [1] truncated
   output logic        rsp_tlast    // last_of_frame
);

   // --------------------------------------------------------------------------
   // State registers
   // --------------------------------------------------------------------------
   id3fs_pkg::phase_type               phase_ff, phase_in;
   id3fs_pkg::window_type              win_ff, win_in;
   logic [id3fs_pkg::FILL_W-1:0]       fill_ff, fill_in;
   logic [id3fs_pkg::FLAG_W-1:0]       flags_ff, flags_in;
   logic [id3fs_pkg::SIZE_W-1:0]       left_ff, left_in;

   // Result register
   logic                               rsp_valid_ff;
   logic                               kind_ff, kind_in;
   logic [id3fs_pkg::ID_W-1:0]         id_ff, id_in;
   logic [id3fs_pkg::SIZE_W-1:0]       size_ff, size_in;
   logic [7:0]                         pbyte_ff, pbyte_in;
   logic                               last_ff, last_in;
   logic                               trunc_ff, trunc_in;

   logic                               emit;
   logic                               req_fire;

   // Search- and payload-phase helpers
   id3fs_pkg::window_type              win_shift;
   logic [id3fs_pkg::SIZE_W-1:0]       shift_size;
   logic [id3fs_pkg::SIZE_W-1:0]       left_dec;
   logic                               header_match;
   logic                               cut;
   logic                               done;

   // The result register frees up when it is empty or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      for (int i = 0; i < int'(id3fs_pkg::WIN_DEPTH) - 1; i++) begin
         win_shift[i] = win_ff[i+1];
      end
      win_shift[id3fs_pkg::WIN_DEPTH-1] = req_tdata;
      shift_size = id3fs_pkg::syncsafe_size(win_shift);
      left_dec   = left_ff - 1'b1;
      header_match = (fill_ff >= id3fs_pkg::FILL_FULL - 1'b1);
      for (int i = 0; i < int'(id3fs_pkg::ID_BYTES); i++) begin
         if (!id3fs_pkg::is_id_char(win_shift[i])) begin
            header_match = 1'b0;
         end
      end
      for (int i = int'(id3fs_pkg::ID_BYTES); i < int'(id3fs_pkg::WIN_DEPTH); i++) begin
         if (win_shift[i][7]) begin
            header_match = 1'b0;
         end
      end
      cut  = req_tlast && (shift_size != '0);
      done = (left_dec == '0);
   end

   // --------------------------------------------------------------------------
   // Next state and result
   // --------------------------------------------------------------------------
   always_comb begin
      phase_in = phase_ff;
      win_in   = win_ff;
      fill_in  = fill_ff;
      flags_in = flags_ff;
      left_in  = left_ff;
      emit     = 1'b0;
      kind_in  = 1'b0;
      id_in    = id3fs_pkg::window_id(win_ff);
      size_in  = id3fs_pkg::syncsafe_size(win_ff);
      pbyte_in = '0;
      last_in  = 1'b0;
      trunc_in = 1'b0;

      unique case (phase_ff)
         id3fs_pkg::PH_FLAGS: begin
            if (flags_ff > 2'd1) begin
               flags_in = flags_ff - 1'b1;
            end else begin
               flags_in = '0;
               phase_in = (left_ff == '0) ? id3fs_pkg::PH_SCAN : id3fs_pkg::PH_PAYLOAD;
            end
            // Tag ended before any payload of a non-empty frame: marker beat.
            if (req_tlast && (left_ff != '0)) begin
               emit     = 1'b1;
               last_in  = 1'b1;
               trunc_in = 1'b1;
            end
            if ((phase_in == id3fs_pkg::PH_SCAN) || req_tlast) begin
               phase_in = id3fs_pkg::PH_SCAN;
               fill_in  = '0;
               flags_in = '0;
               left_in  = '0;
            end
         end
         id3fs_pkg::PH_PAYLOAD: begin
            left_in  = left_dec;
            emit     = 1'b1;
            kind_in  = 1'b1;
            pbyte_in = req_tdata;
            last_in  = done || req_tlast;
            trunc_in = req_tlast && !done;
            if (done || req_tlast) begin
               phase_in = id3fs_pkg::PH_SCAN;
               fill_in  = '0;
               flags_in = '0;
               left_in  = '0;
            end
         end
         default: begin
            // Searching; an unused phase code behaves the same way.
            win_in   = win_shift;
            phase_in = id3fs_pkg::PH_SCAN;
            if (fill_ff < id3fs_pkg::FILL_FULL) begin
               fill_in = fill_ff + 1'b1;
            end
            id_in   = id3fs_pkg::window_id(win_shift);
            size_in = shift_size;
            if (header_match) begin
               emit     = 1'b1;
               last_in  = (shift_size == '0) || cut;
               trunc_in = cut;
               phase_in = id3fs_pkg::PH_FLAGS;
               flags_in = id3fs_pkg::FLAG_BYTES;
               left_in  = shift_size;
            end
            if (req_tlast) begin
               phase_in = id3fs_pkg::PH_SCAN;
               fill_in  = '0;
               flags_in = '0;
               left_in  = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= id3fs_pkg::PH_SCAN;
         fill_ff  <= '0;
         flags_ff <= '0;
         left_ff  <= '0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
         flags_ff <= flags_in;
         left_ff  <= left_in;
      end
   end

   // The window needs no reset: a header needs eight fresh bytes, and the
   // fields taken from it are only reported after such a header.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         kind_ff  <= kind_in;
         id_ff    <= id_in;
         size_ff  <= size_in;
         pbyte_ff <= pbyte_in;
         last_ff  <= last_in;
         trunc_ff <= trunc_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, pbyte_ff, size_ff, id_ff};
   assign rsp_tuser  = {trunc_ff, kind_ff};
   assign rsp_tlast  = last_ff;

   // --------------------------------------------------------------------------
   // Assertions
   // --------------------------------------------------------------------------
   a_flags_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == id3fs_pkg::PH_FLAGS) |-> (flags_ff != '0))
      else $error("flag phase with no flag bytes left");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == id3fs_pkg::PH_PAYLOAD) |-> (left_ff != '0))
      else $error("payload phase with no payload left");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= id3fs_pkg::FILL_FULL)
      else $error("window fill beyond depth");

   a_payload_beat: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (phase_ff == id3fs_pkg::PH_PAYLOAD)) |=> (rsp_valid_ff && kind_ff))
      else $error("payload byte accepted without a payload result");

   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && trunc_ff) |-> last_ff)
      else $error("truncated result not marked as last of frame");

endmodule

// ===== verif/id3v2_frame_scanner_top_test.sv =====
// -----------------------------------------------------------------------------
// ID3v2 frame scanner testbench
// Streams tag bytes into the scanner with random gaps and back-pressure and
// checks every result beat against a cycle-free model of the frame search.
// -----------------------------------------------------------------------------
//
// The stimulus opens with a handful of hand-built frames: an empty frame, a
// header at the largest syncsafe size cut off by the end of the tag, and a
// header whose tag ends in the first flag byte. After that come random tags
// made mostly of well-formed frames with random ids, sizes, flags and
// payloads, mixed with noise bytes, corrupted headers and tags that end
// part-way through a frame. The model below is updated on every accepted
// input beat and queues the result that beat should produce; the monitor
// compares each accepted result beat against the oldest queued result.
module id3v2_frame_scanner_top_test;

   // One input beat: a tag byte and the end-of-tag marker.
   typedef struct packed {
      logic [7:0] data;
      logic       eot;
   } tag_beat_type;

   // One result beat, field by field.
   typedef struct packed {
      logic                        kind;
      logic [id3fs_pkg::ID_W-1:0]   frame_id;
      logic [id3fs_pkg::SIZE_W-1:0] frame_len;
      logic [7:0]                  payload_byte;
      logic                        last_of_frame;
      logic                        truncated;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        req_tlast  = 1'b0;    // end_of_tag

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;            // [31:0] frame_id, [59:32] frame_len,
                                      // [67:60] payload_byte, [71:68] zero
   logic [1:0]  rsp_tuser;            // [0] kind, [1] truncated
   logic        rsp_tlast;            // last_of_frame

   id3v2_frame_scanner_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Beats still to be sent, and results the scanner still owes us.
   tag_beat_type     pending_beats[$];
   frame_result_type expected_results[$];
   tag_beat_type     next_beat;

   int unsigned total_beats    = 1;
   int unsigned accepted_beats = 0;
   int unsigned error_count    = 0;

   // Model state: the byte window and the frame counters.
   logic [7:0]                   win [id3fs_pkg::WIN_DEPTH];
   logic [id3fs_pkg::FILL_W-1:0] win_fill;
   id3fs_pkg::phase_type         scan_phase;
   logic [id3fs_pkg::FLAG_W-1:0] flags_left;
   logic [id3fs_pkg::SIZE_W-1:0] payload_left;

   string id_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";

   initial begin
      forever #5 clock = ~clock;
   end

   // A generous ceiling: even with heavy idling on both sides a correct run
   // finishes in a small fraction of this.
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Scanner model
   // ---------------------------------------------------------------------------

   task automatic clear_scanner();
      for (int i = 0; i < id3fs_pkg::WIN_DEPTH; i++) begin
         win[i] = 8'h00;
      end
      win_fill     = '0;
      scan_phase   = id3fs_pkg::PH_SCAN;
      flags_left   = '0;
      payload_left = '0;
   endtask

   function automatic logic id_char(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
   endfunction

   // Seven bits from each size byte, most significant byte first.
   function automatic logic [id3fs_pkg::SIZE_W-1:0] window_size();
      return {win[4][6:0], win[5][6:0], win[6][6:0], win[7][6:0]};
   endfunction

   // Id and size always come from the header bytes held in the window.
   function automatic frame_result_type make_result(input logic kind,
                                                    input logic [7:0] pbyte,
                                                    input logic last, input logic trunc);
      frame_result_type r;
      r.kind          = kind;
      r.frame_id      = {win[0], win[1], win[2], win[3]};
      r.frame_len     = window_size();
      r.payload_byte  = pbyte;
      r.last_of_frame = last;
      r.truncated     = trunc;
      return r;
   endfunction

   // Advances the model by one accepted byte and queues any result it causes.
   task automatic scan_tag_byte(input logic [7:0] b, input logic eot);
      frame_result_type             r;
      logic                         produce;
      logic                         hit;
      logic [id3fs_pkg::SIZE_W-1:0] sz;
      produce = 1'b0;
      r       = '0;
      case (scan_phase)
         id3fs_pkg::PH_FLAGS: begin
            if (flags_left > 1) begin
               flags_left = flags_left - 1'b1;
            end else begin
               flags_left = '0;
               scan_phase = (payload_left == 0) ? id3fs_pkg::PH_SCAN
                                                : id3fs_pkg::PH_PAYLOAD;
            end
            // The tag ran out before a non-empty payload started.
            if (eot && payload_left != 0) begin
               r       = make_result(1'b0, 8'h00, 1'b1, 1'b1);
               produce = 1'b1;
            end
            if (scan_phase == id3fs_pkg::PH_SCAN || eot) begin
               clear_scanner();
            end
         end
         id3fs_pkg::PH_PAYLOAD: begin
            payload_left = payload_left - 1'b1;
            r = make_result(1'b1, b, (payload_left == 0) || eot, eot && (payload_left != 0));
            produce = 1'b1;
            if (payload_left == 0 || eot) begin
               clear_scanner();
            end
         end
         default: begin
            for (int i = 0; i < id3fs_pkg::WIN_DEPTH - 1; i++) begin
               win[i] = win[i+1];
            end
            win[id3fs_pkg::WIN_DEPTH-1] = b;
            if (win_fill < id3fs_pkg::FILL_FULL) begin
               win_fill = win_fill + 1'b1;
            end
            hit = (win_fill >= id3fs_pkg::FILL_FULL);
            for (int i = 0; i < id3fs_pkg::ID_BYTES; i++) begin
               if (!id_char(win[i])) hit = 1'b0;
            end
            for (int i = id3fs_pkg::ID_BYTES; i < id3fs_pkg::WIN_DEPTH; i++) begin
               if (win[i][7]) hit = 1'b0;
            end
            if (hit) begin
               sz = window_size();
               r = make_result(1'b0, 8'h00, (sz == 0) || (eot && sz != 0), eot && sz != 0);
               produce      = 1'b1;
               scan_phase   = id3fs_pkg::PH_FLAGS;
               flags_left   = id3fs_pkg::FLAG_BYTES;
               payload_left = sz;
            end
            if (eot) begin
               clear_scanner();
            end
         end
      endcase
      if (produce) begin
         expected_results.push_back(r);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   task automatic push_beat(input logic [7:0] data, input logic eot);
      tag_beat_type t;
      t.data = data;
      t.eot  = eot;
      pending_beats.push_back(t);
   endtask

   // Appends one frame to a tag under construction. Most frames are clean;
   // some carry a bad id character or a size byte with its top bit set, and
   // a frame closing a tag may claim a size far larger than what follows.
   task automatic add_frame(ref logic [7:0] tag[$], input bit closes_tag);
      int unsigned pick;
      int unsigned body;
      logic [7:0]  size_bytes [4];
      pick = $urandom_range(0, 99);
      for (int i = 0; i < 4; i++) begin
         tag.push_back(id_alphabet[$urandom_range(0, 35)]);
      end
      if ($urandom_range(0, 99) < 8) begin
         tag[tag.size() - 1 - $urandom_range(0, 3)] = 8'($urandom_range(0, 255));
      end
      size_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
      if (pick < 15) begin
         body = 0;
      end else if (pick < 88 || !closes_tag) begin
         body = $urandom_range(1, 12);
         size_bytes[3] = 8'(body);
      end else begin
         // Large syncsafe size; the tag ends long before the payload would.
         for (int i = 0; i < 4; i++) begin
            size_bytes[i] = 8'($urandom_range(0, 127));
         end
         body = $urandom_range(0, 5);
      end
      if ($urandom_range(0, 99) < 5) begin
         size_bytes[2'($urandom_range(0, 3))][7] = 1'b1;
      end
      for (int i = 0; i < 4; i++) begin
         tag.push_back(size_bytes[i]);
      end
      tag.push_back(8'($urandom_range(0, 255)));
      tag.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < body; i++) begin
         tag.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // One random tag: a few segments of noise or frames, the last one possibly
   // cut short so that the tag ends inside a header, a flag byte or a payload.
   task automatic add_random_tag();
      logic [7:0]  tag[$];
      int unsigned segments;
      int unsigned last_start;
      segments = $urandom_range(1, 4);
      for (int s = 0; s < segments; s++) begin
         last_start = tag.size();
         if ($urandom_range(0, 99) < 25) begin
            repeat ($urandom_range(1, 6)) tag.push_back(8'($urandom_range(0, 255)));
         end else begin
            add_frame(tag, s == segments - 1);
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(0, tag.size() - last_start - 1)) void'(tag.pop_back());
      end
      foreach (tag[i]) begin
         push_beat(tag[i], i == tag.size() - 1);
      end
   endtask

   task automatic build_stimulus();
      // Empty frame: the header itself is the last beat of the frame, and the
      // two flag bytes are still skipped.
      push_beat("A", 1'b0); push_beat("0", 1'b0); push_beat("Z", 1'b0); push_beat("9", 1'b0);
      repeat (4) push_beat(8'h00, 1'b0);
      push_beat(8'hFF, 1'b0); push_beat(8'h00, 1'b0);
      // Largest size, with the tag ending on the header's final byte.
      push_beat("Z", 1'b0); push_beat("Z", 1'b0); push_beat("9", 1'b0); push_beat("9", 1'b0);
      push_beat(8'h7F, 1'b0); push_beat(8'h7F, 1'b0); push_beat(8'h7F, 1'b0);
      push_beat(8'h7F, 1'b1);
      // Size one, with the tag ending in the first flag byte.
      push_beat("9", 1'b0); push_beat("A", 1'b0); push_beat("0", 1'b0); push_beat("Z", 1'b0);
      repeat (3) push_beat(8'h00, 1'b0);
      push_beat(8'h01, 1'b0);
      push_beat(8'h80, 1'b1);
      while (pending_beats.size() < 830) begin
         add_random_tag();
      end
   endtask

   // ---------------------------------------------------------------------------
   // Driver, receiver and monitor
   // ---------------------------------------------------------------------------

   // The run is split into thirds by accepted beats: first the sender is the
   // lighter idler and the receiver the heavier, then the reverse, then
   // neither idles at all.
   function automatic int unsigned sender_idle_pct();
      case (accepted_beats * 3 / total_beats)
         0:       return 32;
         1:       return 79;
         default: return 0;
      endcase
   endfunction

   function automatic int unsigned receiver_idle_pct();
      case (accepted_beats * 3 / total_beats)
         0:       return 79;
         1:       return 32;
         default: return 0;
      endcase
   endfunction

   // A new beat is loaded only when the current one has been taken (or there
   // is none), so tvalid never drops while a beat is on offer.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_beats.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
            next_beat  = pending_beats.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_beat.data;
            req_tlast  <= next_beat.eot;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
   end

   // Input and output are watched in one block so that a prediction is
   // always queued before any result beat of the same edge is checked.
   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         clear_scanner();
      end else begin
         if (req_tvalid && req_tready) begin
            scan_tag_byte(req_tdata, req_tlast);
            accepted_beats <= accepted_beats + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result beat with no result expected: tdata %h tuser %b tlast %b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser[0] !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_tuser[0]);
                  error_count++;
               end
               if (rsp_tdata[31:0] !== want.frame_id) begin
                  $error("frame_id: expected %h, got %h", want.frame_id, rsp_tdata[31:0]);
                  error_count++;
               end
               if (rsp_tdata[59:32] !== want.frame_len) begin
                  $error("frame_len: expected %0d, got %0d", want.frame_len,
                         rsp_tdata[59:32]);
                  error_count++;
               end
               if (rsp_tdata[67:60] !== want.payload_byte) begin
                  $error("payload_byte: expected %h, got %h", want.payload_byte,
                         rsp_tdata[67:60]);
                  error_count++;
               end
               if (rsp_tlast !== want.last_of_frame) begin
                  $error("last_of_frame: expected %0d, got %0d", want.last_of_frame, rsp_tlast);
                  error_count++;
               end
               if (rsp_tuser[1] !== want.truncated) begin
                  $error("truncated: expected %0d, got %0d", want.truncated, rsp_tuser[1]);
                  error_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Run control
   // ---------------------------------------------------------------------------

   // Reset is held while the beat list is built. Checks on
   // progress are made on the falling edge, clear of the rising-edge updates.
   initial begin
      build_stimulus();
      total_beats = pending_beats.size();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (pending_beats.size() != 0 || req_tvalid) begin
         @(negedge clock);
      end
      while (expected_results.size() != 0) begin
         @(negedge clock);
      end
      // Waiting on lets a stray extra result after the last expected one show.
      repeat (8) @(negedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/id3fs_pkg.sv
rtl/core/id3v2_frame_scanner_top.sv
verif/id3v2_frame_scanner_top_test.sv
